// ===== design/srsw_pkg.sv =====
`timescale 1ns / 1ps

package srsw_pkg;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int SEQ_IO_W = 3;
    localparam int PAY_W    = 64;
    localparam int ACT_W    = 3;
    localparam int CFG_W    = 3;

    // Stream data widths (byte padded)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_REFUSED = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SENT    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ACKED   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROPPED = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UNOCC   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RESEND  = 3'd5;

    // Reset value of the window size register
    localparam logic [CFG_W-1:0] WINDOW_RESET = 3'd4;

    typedef logic [PAY_W-1:0] payload_t;

endpackage

// ===== design/selective_repeat_sender_window_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Signals                  Contents (lowest bit up)
// s_axis    in   s_tvalid/s_tready        s_tuser: command[1:0]
//                s_tdata[71:0]            seq_number, checksum_ok, payload, pad
// m_axis    out  m_tvalid/m_tready        m_tuser: action[2:0]
//                m_tdata[71:0]            out_seq, out_payload, window_full,
//                                         window_base, pad
// cfg       in   cfg_we/cfg_wdata[2:0]    window_size, written on cfg_we
//
// Steps: a send, timeout or plain ack runs accept, check, result; an ack for
// the base adds a slide step between check and result that moves the base
// over acked slots. All window tests go through one distance/compare unit.
// Reset: async active low; base and next free at 1, slot flags cleared, window
// size 4. Payload RAM is not cleared.
// Stalls: input is taken only while the sequencer is idle; a finished result
// waits in the output register and the next result waits in the last step
// until the output register frees up.
module selective_repeat_sender_window_core #(
    parameter int SEQ_BITS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config
    input  logic                            cfg_we,
    input  logic [srsw_pkg::CFG_W-1:0]      cfg_wdata,    // window_size
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srsw_pkg::S_TDATA_W-1:0]  s_tdata,      // seq_number, checksum_ok, payload
    input  logic [srsw_pkg::CMD_W-1:0]      s_tuser,      // command
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srsw_pkg::M_TDATA_W-1:0]  m_tdata,      // out_seq, out_payload, window_full, window_base
    output logic [srsw_pkg::ACT_W-1:0]      m_tuser       // action
);

    import srsw_pkg::*;

    localparam int SEQ_SPACE = 1 << SEQ_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SLIDE = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    // Control state
    logic [1:0]           state_reg, state_next;
    logic [CFG_W-1:0]     window_reg;
    logic [SEQ_BITS-1:0]  base_reg, base_next;
    logic [SEQ_BITS-1:0]  nfree_reg, nfree_next;
    logic [SEQ_SPACE-1:0] occ_reg, occ_next;
    logic [SEQ_SPACE-1:0] ack_reg, ack_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic                 ck_reg, ck_next;
    logic                 out_valid_reg, out_valid_next;

    // Working data
    logic [SEQ_BITS-1:0]  seq_reg, seq_next;
    logic [SEQ_BITS-1:0]  oseq_reg, oseq_next;
    payload_t             pay_reg, pay_next;

    // Output register
    logic [ACT_W-1:0]     out_act_reg, out_act_next;
    logic [SEQ_IO_W-1:0]  out_seq_reg, out_seq_next;
    payload_t             out_pay_reg, out_pay_next;
    logic                 out_full_reg, out_full_next;
    logic [SEQ_IO_W-1:0]  out_base_reg, out_base_next;

    // Shared unit and RAM hookup
    logic [SEQ_BITS-1:0]  dist_op;
    logic                 in_window;
    logic                 ram_we;
    logic                 ram_re;
    payload_t             ram_rdata;

    srsw_dist_unit #(
        .SEQ_BITS (SEQ_BITS)
    ) u_dist (
        .operand     (dist_op),
        .base        (base_reg),
        .window_size (window_reg),
        .in_window   (in_window)
    );

    srsw_ram #(
        .WIDTH (PAY_W),
        .DEPTH (SEQ_SPACE)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nfree_reg),
        .wdata (pay_reg),
        .re    (ram_re),
        .raddr (seq_reg),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_act_reg;
    assign m_tdata  = {1'b0, out_base_reg, out_full_reg, out_pay_reg, out_seq_reg};

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        nfree_next     = nfree_reg;
        occ_next       = occ_reg;
        ack_next       = ack_reg;
        cmd_next       = cmd_reg;
        act_next       = act_reg;
        ck_next        = ck_reg;
        seq_next       = seq_reg;
        oseq_next      = oseq_reg;
        pay_next       = pay_reg;
        out_act_next   = out_act_reg;
        out_seq_next   = out_seq_reg;
        out_pay_next   = out_pay_reg;
        out_full_next  = out_full_reg;
        out_base_next  = out_base_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        dist_op        = nfree_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    seq_next   = SEQ_BITS'(s_tdata[2:0]);
                    ck_next    = s_tdata[3];
                    pay_next   = s_tdata[67:4];
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                dist_op    = (cmd_reg == CMD_SEND) ? nfree_reg : seq_reg;
                oseq_next  = seq_reg;
                state_next = ST_FINAL;
                case (cmd_reg)
                    CMD_SEND:
                    begin
                        oseq_next = nfree_reg;
                        if (!in_window)
                        begin
                            act_next = ACT_REFUSED;
                        end
                        else
                        begin
                            ram_we              = 1'b1;
                            occ_next[nfree_reg] = 1'b1;
                            ack_next[nfree_reg] = 1'b0;
                            act_next            = ACT_SENT;
                            nfree_next          = nfree_reg + SEQ_BITS'(1);
                        end
                    end
                    CMD_ACK:
                    begin
                        if (!ck_reg || !in_window)
                        begin
                            act_next = ACT_DROPPED;
                        end
                        else if (!occ_reg[seq_reg])
                        begin
                            act_next = ACT_UNOCC;
                        end
                        else
                        begin
                            ack_next[seq_reg] = 1'b1;
                            act_next          = ACT_ACKED;
                            if (seq_reg == base_reg)
                            begin
                                state_next = ST_SLIDE;
                            end
                        end
                    end
                    CMD_TIMEOUT:
                    begin
                        ram_re   = 1'b1;
                        act_next = ACT_RESEND;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;    // unknown command: no result
                    end
                endcase
            end

            ST_SLIDE:
            begin
                // one slot per cycle; stops at a gap or at next free
                if ((base_reg != nfree_reg) && ack_reg[base_reg])
                begin
                    occ_next[base_reg] = 1'b0;
                    ack_next[base_reg] = 1'b0;
                    base_next          = base_reg + SEQ_BITS'(1);
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                dist_op = nfree_reg;
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = act_reg;
                    out_seq_next   = SEQ_IO_W'(oseq_reg);
                    out_full_next  = ~in_window;
                    out_base_next  = SEQ_IO_W'(base_reg);
                    case (act_reg)
                        ACT_SENT:   out_pay_next = pay_reg;
                        ACT_RESEND: out_pay_next = ram_rdata;
                        default:    out_pay_next = '0;
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            base_reg      <= SEQ_BITS'(1);
            nfree_reg     <= SEQ_BITS'(1);
            occ_reg       <= '0;
            ack_reg       <= '0;
            cmd_reg       <= CMD_SEND;
            act_reg       <= ACT_REFUSED;
            ck_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            nfree_reg     <= nfree_next;
            occ_reg       <= occ_next;
            ack_reg       <= ack_next;
            cmd_reg       <= cmd_next;
            act_reg       <= act_next;
            ck_reg        <= ck_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        oseq_reg     <= oseq_next;
        pay_reg      <= pay_next;
        out_act_reg  <= out_act_next;
        out_seq_reg  <= out_seq_next;
        out_pay_reg  <= out_pay_next;
        out_full_reg <= out_full_next;
        out_base_reg <= out_base_next;
    end

    // An acked slot is always occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ack_reg & ~occ_reg) == '0)
    else $error("acked slot not occupied");

    // Slots between base and next free are in flight, so the base slot is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && (base_reg != nfree_reg) |-> occ_reg[base_reg])
    else $error("base slot free while window not empty");

    // The next free slot never holds an outstanding transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !occ_reg[nfree_reg])
    else $error("next free slot is occupied");

    // A new result appears only out of the final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINAL)
    else $error("result loaded outside final step");

endmodule

// ===== design/srsw_ram.sv =====
`timescale 1ns / 1ps

module srsw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/srsw_dist_unit.sv =====
`timescale 1ns / 1ps

// Shared window test: distance of a sequence number from the base,
// compared against the saturated window size.
module srsw_dist_unit #(
    parameter int SEQ_BITS = 3
) (
    input  logic [SEQ_BITS-1:0]       operand,
    input  logic [SEQ_BITS-1:0]       base,
    input  logic [srsw_pkg::CFG_W-1:0] window_size,
    output logic                      in_window
);

    import srsw_pkg::*;

    localparam int CW = (SEQ_BITS > CFG_W) ? SEQ_BITS : CFG_W;

    logic [CW-1:0]       half;
    logic [CW-1:0]       win;
    logic [CW-1:0]       eff;
    logic [SEQ_BITS-1:0] diff;
    logic [CW-1:0]       offset;

    always_comb
    begin
        half = CW'(1) << (SEQ_BITS - 1);
        win  = CW'(window_size);
        if (win == '0)
        begin
            eff = CW'(1);
        end
        else if (win > half)
        begin
            eff = half;
        end
        else
        begin
            eff = win;
        end
        diff      = operand - base;     // wraps modulo the sequence space
        offset    = CW'(diff);
        in_window = (offset < eff);
    end

endmodule
